[src/lmsc_pkg.sv]
// Shared constants for the min-sum check-node update block.
package lmsc_pkg;

    // Number of columns in one parity-check row; one input message per column.
    localparam int COLUMNS = 5;

    // Bits needed to name one column.
    localparam int COL_IDX_BITS = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Defaults for the top-level parameters.
    localparam int ROWS_DEF     = 4;
    localparam int LLR_BITS_DEF = 8;

    // Only the low 64 bits of the parity-check matrix are ever connected.
    localparam int MATRIX_KEEP_BITS = 64;

    // Reset contents of the matrix register, rows {1,1,1,0,1}, {0,1,1,1,0},
    // {1,1,0,1,0} and {1,0,1,0,1}.
    localparam logic [63:0] MATRIX_RESET = 64'd699863;

endpackage

[src/lmsc_lane_in.sv]
// Input lane: splits one message into a saturated magnitude and a sign.
module lmsc_lane_in #(
    parameter int LLR_BITS = lmsc_pkg::LLR_BITS_DEF
) (
    input  logic signed [LLR_BITS-1:0] llr,
    output logic        [LLR_BITS-2:0] mag,
    output logic                       neg
);

    localparam logic [LLR_BITS-1:0] LLR_MIN = {1'b1, {(LLR_BITS-1){1'b0}}};
    localparam logic [LLR_BITS-2:0] MAG_MAX = {(LLR_BITS-1){1'b1}};

    logic [LLR_BITS-1:0] negated;

    assign neg     = llr[LLR_BITS-1];
    assign negated = LLR_BITS'(-llr);

    // The most negative code has no positive twin, so it saturates.
    always_comb begin
        if (!neg) begin
            mag = llr[LLR_BITS-2:0];
        end else if (llr == LLR_MIN) begin
            mag = MAG_MAX;
        end else begin
            mag = negated[LLR_BITS-2:0];
        end
    end

endmodule

[src/lmsc_merge.sv]
// Merging tree: smallest and second smallest magnitude, its column, and sign parity.
module lmsc_merge #(
    parameter int LLR_BITS = lmsc_pkg::LLR_BITS_DEF
) (
    input  logic [LLR_BITS-2:0]               mag    [lmsc_pkg::COLUMNS],
    input  logic [lmsc_pkg::COLUMNS-1:0]      neg,
    input  logic [lmsc_pkg::COLUMNS-1:0]      conn,
    output logic [LLR_BITS-2:0]               min1,
    output logic [LLR_BITS-2:0]               min2,
    output logic [lmsc_pkg::COL_IDX_BITS-1:0] min_pos,
    output logic                              parity
);

    localparam int PB     = lmsc_pkg::COL_IDX_BITS;
    localparam int LEAVES = 1 << PB;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam logic [LLR_BITS-2:0] MAG_MAX = {(LLR_BITS-1){1'b1}};

    logic [LLR_BITS-2:0] n_min1 [NODES];
    logic [LLR_BITS-2:0] n_min2 [NODES];
    logic [PB-1:0]       n_pos  [NODES];

    genvar i;
    generate
        for (i = 0; i < LEAVES; i++) begin : g_leaf
            if (i < lmsc_pkg::COLUMNS) begin : g_real
                // An unconnected column enters as the largest magnitude.
                assign n_min1[LEAVES-1+i] = conn[i] ? mag[i] : MAG_MAX;
                assign n_min2[LEAVES-1+i] = MAG_MAX;
                assign n_pos[LEAVES-1+i]  = PB'(i);
            end else begin : g_pad
                assign n_min1[LEAVES-1+i] = MAG_MAX;
                assign n_min2[LEAVES-1+i] = MAG_MAX;
                assign n_pos[LEAVES-1+i]  = '0;
            end
        end

        for (i = 0; i < LEAVES - 1; i++) begin : g_node
            logic right_wins;

            // On a tie the left side wins, so the first column of the minimum
            // is the one that receives the second minimum.
            assign right_wins = n_min1[2*i+2] < n_min1[2*i+1];
            assign n_min1[i]  = right_wins ? n_min1[2*i+2] : n_min1[2*i+1];
            assign n_pos[i]   = right_wins ? n_pos[2*i+2] : n_pos[2*i+1];
            assign n_min2[i]  = right_wins ?
                                ((n_min1[2*i+1] < n_min2[2*i+2]) ?
                                 n_min1[2*i+1] : n_min2[2*i+2]) :
                                ((n_min2[2*i+1] < n_min1[2*i+2]) ?
                                 n_min2[2*i+1] : n_min1[2*i+2]);
        end
    endgenerate

    assign min1    = n_min1[0];
    assign min2    = n_min2[0];
    assign min_pos = n_pos[0];
    assign parity  = ^(neg & conn);

endmodule

[src/lmsc_lane_out.sv]
// Output lane: forms one column's updated message from the merged row result.
module lmsc_lane_out #(
    parameter int LLR_BITS = lmsc_pkg::LLR_BITS_DEF,
    parameter int LANE     = 0
) (
    input  logic [LLR_BITS-2:0]               min1,
    input  logic [LLR_BITS-2:0]               min2,
    input  logic [lmsc_pkg::COL_IDX_BITS-1:0] min_pos,
    input  logic                              parity,
    input  logic                              neg,
    input  logic                              conn,
    output logic signed [LLR_BITS-1:0]        msg
);

    localparam int PB = lmsc_pkg::COL_IDX_BITS;

    logic [LLR_BITS-2:0] mag_sel;
    logic [LLR_BITS-1:0] mag_ext;
    logic                flip;

    // The column that holds the minimum sees the second smallest instead.
    assign mag_sel = (min_pos == PB'(LANE)) ? min2 : min1;
    assign mag_ext = {1'b0, mag_sel};
    // Removing this column's own sign from the row parity.
    assign flip    = parity ^ neg;

    always_comb begin
        if (!conn) begin
            msg = '0;
        end else if (flip) begin
            msg = LLR_BITS'(-mag_ext);
        end else begin
            msg = mag_ext;
        end
    end

endmodule

[src/ldpc_min_sum_check_node.sv]
// Top level of the min-sum check-node update: matrix register, lanes and pipeline.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | s_valid / s_ready   | s_row_index, s_llr_in_0 .. s_llr_in_4
//  result   | m_valid / m_ready   | m_row_out, m_msg_out_0 .. m_msg_out_4
//  config   | cfg_wr_en           | cfg_wr_data (parity-check matrix)
//
// One item is taken per cycle while s_ready is high. Each item passes through
// a stage register, fed by the input lanes and row lookup, and then the output
// register, fed by the merging tree and output lanes. s_ready drops only when
// both stages are full and m_ready is low. Reset loads the default matrix
// and empties both stages.
module ldpc_min_sum_check_node #(
    parameter  int ROWS     = lmsc_pkg::ROWS_DEF,
    parameter  int LLR_BITS = lmsc_pkg::LLR_BITS_DEF,
    localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int MAT_BITS = ROWS * lmsc_pkg::COLUMNS
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic [MAT_BITS-1:0]        cfg_wr_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ROW_BITS-1:0]        s_row_index,
    input  logic signed [LLR_BITS-1:0] s_llr_in_0,
    input  logic signed [LLR_BITS-1:0] s_llr_in_1,
    input  logic signed [LLR_BITS-1:0] s_llr_in_2,
    input  logic signed [LLR_BITS-1:0] s_llr_in_3,
    input  logic signed [LLR_BITS-1:0] s_llr_in_4,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [ROW_BITS-1:0]        m_row_out,
    output logic signed [LLR_BITS-1:0] m_msg_out_0,
    output logic signed [LLR_BITS-1:0] m_msg_out_1,
    output logic signed [LLR_BITS-1:0] m_msg_out_2,
    output logic signed [LLR_BITS-1:0] m_msg_out_3,
    output logic signed [LLR_BITS-1:0] m_msg_out_4
);

    localparam int COLS = lmsc_pkg::COLUMNS;
    localparam int PB   = lmsc_pkg::COL_IDX_BITS;
    localparam logic [MAT_BITS-1:0] MAT_RESET = MAT_BITS'(lmsc_pkg::MATRIX_RESET);

    logic [MAT_BITS-1:0] matrix_reg;

    logic signed [LLR_BITS-1:0] llr_in  [COLS];
    logic [LLR_BITS-2:0]        mag_in  [COLS];
    logic [COLS-1:0]            neg_in;
    logic [COLS-1:0]            row_conn [ROWS];
    logic [COLS-1:0]            conn_sel;

    // Stage register between the input lanes and the merging tree.
    logic                       st_valid_reg;
    logic [ROW_BITS-1:0]        st_row_reg;
    logic [LLR_BITS-2:0]        st_mag_reg [COLS];
    logic [COLS-1:0]            st_neg_reg;
    logic [COLS-1:0]            st_conn_reg;
    logic                       st_ready;

    logic [LLR_BITS-2:0]        min1;
    logic [LLR_BITS-2:0]        min2;
    logic [PB-1:0]              min_pos;
    logic                       parity;
    logic signed [LLR_BITS-1:0] msg_next [COLS];

    logic                       m_valid_reg;
    logic [ROW_BITS-1:0]        m_row_reg;
    logic signed [LLR_BITS-1:0] m_msg_reg [COLS];

    assign llr_in[0] = s_llr_in_0;
    assign llr_in[1] = s_llr_in_1;
    assign llr_in[2] = s_llr_in_2;
    assign llr_in[3] = s_llr_in_3;
    assign llr_in[4] = s_llr_in_4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_reg <= MAT_RESET;
        end else if (cfg_wr_en) begin
            matrix_reg <= cfg_wr_data;
        end
    end

    genvar r, c;
    generate
        for (r = 0; r < ROWS; r++) begin : g_row
            for (c = 0; c < COLS; c++) begin : g_col
                // Matrix bits past the first 64 never connect.
                if (r * COLS + c < lmsc_pkg::MATRIX_KEEP_BITS) begin : g_keep
                    assign row_conn[r][c] = matrix_reg[r*COLS+c];
                end else begin : g_drop
                    assign row_conn[r][c] = 1'b0;
                end
            end
        end

        for (c = 0; c < COLS; c++) begin : g_lane_in
            lmsc_lane_in #(
                .LLR_BITS (LLR_BITS)
            ) u_lane_in (
                .llr (llr_in[c]),
                .mag (mag_in[c]),
                .neg (neg_in[c])
            );
        end
    endgenerate

    // A row index past the last row behaves as an empty row.
    always_comb begin
        if (32'(s_row_index) < ROWS) begin
            conn_sel = row_conn[s_row_index];
        end else begin
            conn_sel = '0;
        end
    end

    assign st_ready = !m_valid_reg || m_ready;
    assign s_ready  = !st_valid_reg || st_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            st_row_reg  <= s_row_index;
            st_mag_reg  <= mag_in;
            st_neg_reg  <= neg_in;
            st_conn_reg <= conn_sel;
        end
    end

    lmsc_merge #(
        .LLR_BITS (LLR_BITS)
    ) u_merge (
        .mag     (st_mag_reg),
        .neg     (st_neg_reg),
        .conn    (st_conn_reg),
        .min1    (min1),
        .min2    (min2),
        .min_pos (min_pos),
        .parity  (parity)
    );

    generate
        for (c = 0; c < COLS; c++) begin : g_lane_out
            lmsc_lane_out #(
                .LLR_BITS (LLR_BITS),
                .LANE     (c)
            ) u_lane_out (
                .min1    (min1),
                .min2    (min2),
                .min_pos (min_pos),
                .parity  (parity),
                .neg     (st_neg_reg[c]),
                .conn    (st_conn_reg[c]),
                .msg     (msg_next[c])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_ready) begin
            m_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_ready && st_valid_reg) begin
            m_row_reg <= st_row_reg;
            m_msg_reg <= msg_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row_out   = m_row_reg;
    assign m_msg_out_0 = m_msg_reg[0];
    assign m_msg_out_1 = m_msg_reg[1];
    assign m_msg_out_2 = m_msg_reg[2];
    assign m_msg_out_3 = m_msg_reg[3];
    assign m_msg_out_4 = m_msg_reg[4];

endmodule

[test/tb_ldpc_min_sum_check_node.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the min-sum check-node update block.
module tb_ldpc_min_sum_check_node;

    localparam int ROWS  = lmsc_pkg::ROWS_DEF;
    localparam int LLR_W = lmsc_pkg::LLR_BITS_DEF;
    localparam int COLS  = lmsc_pkg::COLUMNS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MAT_W = ROWS * COLS;

    localparam logic [MAT_W-1:0] MAT_RESET  = MAT_W'(lmsc_pkg::MATRIX_RESET);
    localparam logic [MAT_W-1:0] MAT_EMPTY  = '0;
    localparam logic [MAT_W-1:0] MAT_FULL   = '1;
    // Each row connects to exactly one column, on the diagonal.
    localparam logic [MAT_W-1:0] MAT_SINGLE = 20'h41041;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int SINK_HOLD    = 80;
    localparam int SETTLE       = 4;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 96;
    localparam int MAX_REPORTS  = 10;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic signed [LLR_W-1:0] llr_t;

    typedef struct packed {
        row_t             row;
        llr_t [0:COLS-1]  msg;
    } cn_item_t;

    typedef struct packed {
        logic [MAT_W-1:0] matrix;
        logic             typed;
        cn_item_t         stim;
        cn_item_t         want;
    } dir_case_t;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [MAT_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    row_t             s_row_index = '0;
    llr_t             s_llr_in_0  = '0;
    llr_t             s_llr_in_1  = '0;
    llr_t             s_llr_in_2  = '0;
    llr_t             s_llr_in_3  = '0;
    llr_t             s_llr_in_4  = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    row_t             m_row_out;
    llr_t             m_msg_out_0;
    llr_t             m_msg_out_1;
    llr_t             m_msg_out_2;
    llr_t             m_msg_out_3;
    llr_t             m_msg_out_4;

    cn_item_t         owed_updates [$];
    dir_case_t        dir_cases [$];
    logic [MAT_W-1:0] matrix_now    = MAT_RESET;
    bit               calm          = 1'b0;
    bit               hold_sink     = 1'b0;
    int               items_sent    = 0;
    int               updates_seen  = 0;
    int               field_errors  = 0;
    int               settings_used = 0;
    int               quiet_cycles  = 0;

    ldpc_min_sum_check_node u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_row_index (s_row_index),
        .s_llr_in_0  (s_llr_in_0),
        .s_llr_in_1  (s_llr_in_1),
        .s_llr_in_2  (s_llr_in_2),
        .s_llr_in_3  (s_llr_in_3),
        .s_llr_in_4  (s_llr_in_4),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_out   (m_row_out),
        .m_msg_out_0 (m_msg_out_0),
        .m_msg_out_1 (m_msg_out_1),
        .m_msg_out_2 (m_msg_out_2),
        .m_msg_out_3 (m_msg_out_3),
        .m_msg_out_4 (m_msg_out_4)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Each connected column gets the smallest magnitude of the other connected
    // columns, signed by the product of their signs.
    function automatic cn_item_t min_sum_update(input cn_item_t stim,
                                                input logic [MAT_W-1:0] h);
        cn_item_t   res;
        logic [7:0] raw;
        logic [7:0] absval;
        logic [6:0] mag_of [COLS];
        bit         neg_of [COLS];
        bit         conn_of [COLS];
        logic [6:0] least;
        logic [6:0] runner;
        logic [6:0] pick;
        int         least_col;
        bit         odd;
        res       = '0;
        res.row   = stim.row;
        least     = 7'd127;
        runner    = 7'd127;
        least_col = 0;
        odd       = 1'b0;
        for (int c = 0; c < COLS; c++) begin
            raw        = stim.msg[c];
            neg_of[c]  = raw[7];
            absval     = neg_of[c] ? (~raw + 8'd1) : raw;
            // The most negative input stays 0x80 after negation and saturates.
            mag_of[c]  = (absval > 8'd127) ? 7'd127 : absval[6:0];
            conn_of[c] = h[int'(stim.row) * COLS + c];
            if (conn_of[c]) begin
                odd = odd ^ neg_of[c];
                if (mag_of[c] < least) begin
                    runner    = least;
                    least     = mag_of[c];
                    least_col = c;
                end else if (mag_of[c] < runner) begin
                    runner = mag_of[c];
                end
            end
        end
        for (int c = 0; c < COLS; c++) begin
            if (conn_of[c]) begin
                pick = (c == least_col) ? runner : least;
                res.msg[c] = (odd ^ neg_of[c]) ? (~{1'b0, pick} + 8'd1) : {1'b0, pick};
            end
        end
        return res;
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix of full-range values, tiny magnitudes that force ties and zeros,
    // and the extremes of the field.
    function automatic llr_t rand_llr();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return llr_t'($urandom());
        if (pick < 8) return llr_t'(int'($urandom_range(0, 8)) - 4);
        if (pick == 8) begin
            case ($urandom_range(0, 5))
                0: return llr_t'(-128);
                1: return llr_t'(127);
                2: return llr_t'(-127);
                3: return llr_t'(0);
                4: return llr_t'(-1);
                default: return llr_t'(1);
            endcase
        end
        return llr_t'(int'($urandom_range(0, 31)) - 16);
    endfunction

    task automatic add_case(input logic [MAT_W-1:0] h, input bit typed, input int row,
                            input int a0, a1, a2, a3, a4,
                            input int w0, w1, w2, w3, w4);
        dir_case_t dc;
        dc.matrix    = h;
        dc.typed     = typed;
        dc.stim.row  = row_t'(row);
        dc.stim.msg  = {llr_t'(a0), llr_t'(a1), llr_t'(a2), llr_t'(a3), llr_t'(a4)};
        dc.want.row  = row_t'(row);
        dc.want.msg  = {llr_t'(w0), llr_t'(w1), llr_t'(w2), llr_t'(w3), llr_t'(w4)};
        dir_cases.push_back(dc);
    endtask

    // Called right after an edge; returns at the edge where the item is taken.
    task automatic offer_item(input cn_item_t stim, input bit typed, input cn_item_t want);
        int gap;
        gap = (calm || hold_sink) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_index <= stim.row;
        s_llr_in_0  <= stim.msg[0];
        s_llr_in_1  <= stim.msg[1];
        s_llr_in_2  <= stim.msg[2];
        s_llr_in_3  <= stim.msg[3];
        s_llr_in_4  <= stim.msg[4];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        owed_updates.push_back(typed ? want : min_sum_update(stim, matrix_now));
        items_sent++;
    endtask

    task automatic wait_all_answered();
        s_valid <= 1'b0;
        while (owed_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_matrix(input logic [MAT_W-1:0] h);
        wait_all_answered();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= h;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        matrix_now = h;
        settings_used++;
    endtask

    task automatic report_mismatch(input string what, input int want_val, input int got_val);
        field_errors++;
        if (field_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_val, got_val);
    endtask

    // Receiver: bursts of ready with random stalls, always ready in calm phases, and one long hold-off on request.
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                gap = idle_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cn_item_t got;
        cn_item_t want;
        if (aresetn && m_valid && m_ready) begin
            got.row    = m_row_out;
            got.msg[0] = m_msg_out_0;
            got.msg[1] = m_msg_out_1;
            got.msg[2] = m_msg_out_2;
            got.msg[3] = m_msg_out_3;
            got.msg[4] = m_msg_out_4;
            updates_seen++;
            if (owed_updates.size() == 0) begin
                field_errors++;
                if (field_errors <= MAX_REPORTS)
                    $display("%0t: result for row %0d arrived with no item pending",
                             $time, got.row);
            end else begin
                want = owed_updates.pop_front();
                if (got.row !== want.row)
                    report_mismatch($sformatf("result %0d row_out", updates_seen),
                                    want.row, got.row);
                for (int c = 0; c < COLS; c++) begin
                    if (got.msg[c] !== want.msg[c])
                        report_mismatch($sformatf("result %0d msg_out_%0d", updates_seen, c),
                                        $signed(want.msg[c]), $signed(got.msg[c]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        cn_item_t         stim;
        cn_item_t         none;
        logic [31:0]      draw;
        logic [31:0]      draw2;
        none = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Default matrix: rows {0,1,2,4}, {1,2,3}, {0,1,3}, {0,2,4}.
        add_case(MAT_RESET,  1, 0,    0,    0,    0,    0,    0,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  1, 0,  127,  127,  127,  127,  127,  127,  127,  127, 0,  127);
        add_case(MAT_RESET,  1, 0, -128, -128, -128, -128, -128, -127, -127, -127, 0, -127);
        add_case(MAT_RESET,  1, 1, -127, -127, -127, -127, -127,    0,  127,  127, 127,  0);
        add_case(MAT_RESET,  0, 0,    5,   -3,    7,  100,    9,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 1,    0,   -1,    1, -128,    2,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 2,   -4,    4,   50,   -4,    9,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 3, -128,    0,  127,    5,   -1,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 2,    1,    2,    3,    4,    5,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 3,   -2,   -3,   -4,   -5,   -6,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 1,  127, -128, -128,  127,    0,    0,    0,    0, 0,    0);
        add_case(MAT_RESET,  0, 0,   -1,   -1,   -1,   -1,   -1,    0,    0,    0, 0,    0);
        // A row with no connections answers all zeros.
        add_case(MAT_EMPTY,  1, 2,   10,  -20,   30,  -40,   50,    0,    0,    0, 0,    0);
        add_case(MAT_EMPTY,  1, 0, -128, -128, -128, -128, -128,    0,    0,    0, 0,    0);
        // A lone connected column sees no others and gets +127.
        add_case(MAT_SINGLE, 1, 0, -128, -128, -128, -128, -128,  127,    0,    0, 0,    0);
        add_case(MAT_SINGLE, 1, 3,    5,    5,    5,   -9,    5,    0,    0,    0, 127,  0);
        add_case(MAT_SINGLE, 0, 1,    0,    0,    0,    0,    0,    0,    0,    0, 0,    0);
        add_case(MAT_FULL,   0, 3,    3,   -3,    3,   -3,    3,    0,    0,    0, 0,    0);
        add_case(MAT_FULL,   0, 0,  127, -128,    0,    1,   -1,    0,    0,    0, 0,    0);
        add_case(MAT_FULL,   0, 2,  -50,   60,  -70,   80,  -90,    0,    0,    0, 0,    0);

        foreach (dir_cases[k]) begin
            if (dir_cases[k].matrix !== matrix_now)
                load_matrix(dir_cases[k].matrix);
            offer_item(dir_cases[k].stim, dir_cases[k].typed, dir_cases[k].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            draw  = $urandom();
            draw2 = $urandom();
            case (phase)
                0: load_matrix(MAT_RESET);
                1: load_matrix(MAT_FULL);
                2: load_matrix(MAT_EMPTY);
                3: load_matrix(MAT_SINGLE);
                // Even phases AND two draws so that sparse rows and lone columns show up.
                default: load_matrix(phase[0] ? draw[MAT_W-1:0]
                                              : (draw[MAT_W-1:0] & draw2[MAT_W-1:0]));
            endcase
            calm = (phase % 4 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 6 && i == 30)
                    hold_sink = 1'b1;
                if (phase == 9 && i == 48)
                    wait_all_answered();
                stim.row = row_t'($urandom_range(0, ROWS - 1));
                for (int c = 0; c < COLS; c++)
                    stim.msg[c] = rand_llr();
                offer_item(stim, 1'b0, none);
            end
        end
        calm = 1'b0;
        wait_all_answered();

        $display("Sent %0d items (%0d directed) across %0d matrix settings; %0d results compared.",
                 items_sent, dir_cases.size(), settings_used, updates_seen);
        $display("Field mismatches: %0d", field_errors);
        if (field_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
